[hw/rtl/psfr_pkg.sv]
// psfr_pkg: constants and helpers shared by the pixel span fold/reorder block.
// No dependencies.
package psfr_pkg;

  // Config register widths and indexes
  localparam int COUNT_W = 10;
  localparam int MODE_W  = 2;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_NODE_MODE     = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  // node_mode codes; the unused code behaves as MODE_ONE
  localparam logic [MODE_W-1:0] MODE_ONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGBW = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd512;

  // x/3 for x < 1024 as (x * 683) >> 11
  localparam int DIV3_MUL_W = 11;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 11'd683;
  localparam int DIV3_SHIFT = 11;

  localparam int DATA_W = 8;

  // channels per node for a mode code
  function automatic logic [2:0] node_size(input logic [MODE_W-1:0] mode);
    logic [2:0] s;
    case (mode)
      MODE_RGB:  s = 3'd3;
      MODE_RGBW: s = 3'd4;
      default:   s = 3'd1;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/pixel_span_fold_reorder.sv]
// pixel_span_fold_reorder: folds light-string nodes of a channel span through a
// ping-pong frame memory and streams the previous frame out in order.
// Depends on psfr_pkg.
//
// Throughput: one channel byte per cycle while the output accepts; the only loop
// is the position counter. Output path: the result of a request passes the memory
// read register, then the output register; each frame comes out one frame late,
// and no result is produced until the first frame completes.
// Reset (rst, synchronous): counters, bank select and valid flags clear, config
// returns to node_mode 0 / channel_count 512. Frame memory is not cleared.
module pixel_span_fold_reorder #(
  parameter int MAX_CHANNELS = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic [psfr_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [psfr_pkg::COUNT_W-1:0]   cfg_wdata,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] channel_value
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] folded_value
  output logic                          m_tlast    // frame_last
);
  import psfr_pkg::*;

  // PW: index into one bank; PCW: counters that may hold MAX_CHANNELS itself
  localparam int PW  = $clog2(MAX_CHANNELS);
  localparam int PCW = $clog2(MAX_CHANNELS + 1);
  localparam int AW  = $clog2(2 * MAX_CHANNELS);
  localparam int WW  = ((PCW > COUNT_W) ? PCW : COUNT_W) + 1;
  localparam int SAT = (MAX_CHANNELS < 1023) ? MAX_CHANNELS : 1023;
  localparam logic [COUNT_W-1:0] SAT_C = COUNT_W'(SAT);
  localparam logic [WW-1:0] MAX_W  = WW'(MAX_CHANNELS);
  localparam logic [AW-1:0] BANK_OFS = AW'(MAX_CHANNELS);

  // ---------------------------------------------------------------------------
  // Config registers, plus effective count and node count derived at write
  // time so the data path sees no divide.
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]  node_mode, node_mode_next;
  logic [COUNT_W-1:0] channel_count, channel_count_next;
  logic [COUNT_W-1:0] eff_count, eff_count_next;
  logic [COUNT_W-1:0] node_len, node_len_next;
  logic [COUNT_W+DIV3_MUL_W-1:0] div3_prod;

  always_comb begin
    node_mode_next     = node_mode;
    channel_count_next = channel_count;
    if (rst) begin
      node_mode_next     = MODE_ONE;
      channel_count_next = COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NODE_MODE:     node_mode_next     = cfg_wdata[MODE_W-1:0];
        REG_CHANNEL_COUNT: channel_count_next = cfg_wdata;
        default: ;
      endcase
    end
    // zero count acts as one, large counts clamp to capacity
    if (channel_count_next == '0)
      eff_count_next = COUNT_W'(1);
    else if (channel_count_next > SAT_C)
      eff_count_next = SAT_C;
    else
      eff_count_next = channel_count_next;
    div3_prod = (COUNT_W+DIV3_MUL_W)'(eff_count_next) * (COUNT_W+DIV3_MUL_W)'(DIV3_MUL);
    case (node_mode_next)
      MODE_RGB:  node_len_next = div3_prod[DIV3_SHIFT +: COUNT_W];
      MODE_RGBW: node_len_next = eff_count_next >> 2;
      default:   node_len_next = eff_count_next;
    endcase
  end

  always_ff @(posedge clk) begin
    node_mode     <= node_mode_next;
    channel_count <= channel_count_next;
    eff_count     <= eff_count_next;
    node_len      <= node_len_next;
  end

  // ---------------------------------------------------------------------------
  // Position counters and fold address
  // ---------------------------------------------------------------------------
  logic [PCW-1:0] channel_position;
  logic [PCW-1:0] node_position;
  logic [1:0]     lane_in_node;
  logic           write_bank;
  logic           previous_frame_ready;

  logic           accept;
  logic [2:0]     size;
  logic [1:0]     lane;
  logic [WW-1:0]  pos_w, node_w, len_w, half_w, dnode_w, scaled_w, dest_w;
  logic [PW-1:0]  dest_idx, pos_idx;
  logic           frame_end;
  logic           in_range;

  always_comb begin
    size   = node_size(node_mode);
    // a lane left over from an earlier mode wraps to zero
    lane   = ({1'b0, lane_in_node} >= size) ? 2'd0 : lane_in_node;
    pos_w  = WW'(channel_position);
    node_w = WW'(node_position);
    len_w  = WW'(node_len);
    frame_end = (pos_w + WW'(1)) >= WW'(eff_count);
    in_range  = node_w < len_w;
    half_w  = node_w >> 1;
    dnode_w = node_w[0] ? (len_w - WW'(1) - half_w) : half_w;
    case (size)
      3'd3:    scaled_w = dnode_w + (dnode_w << 1);
      3'd4:    scaled_w = dnode_w << 2;
      default: scaled_w = dnode_w;
    endcase
    // trailing partial node keeps its place
    dest_w = in_range ? (scaled_w + WW'(lane)) : pos_w;
    dest_idx = (dest_w >= MAX_W) ? PW'(MAX_CHANNELS - 1) : dest_w[PW-1:0];
    pos_idx  = (pos_w  >= MAX_W) ? PW'(MAX_CHANNELS - 1) : pos_w[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_position     <= '0;
      node_position        <= '0;
      lane_in_node         <= '0;
      write_bank           <= 1'b0;
      previous_frame_ready <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        channel_position     <= '0;
        node_position        <= '0;
        lane_in_node         <= '0;
        write_bank           <= ~write_bank;
        previous_frame_ready <= 1'b1;
      end else begin
        channel_position <= PCW'(pos_idx) + PCW'(1);
        if ({1'b0, lane} + 3'd1 >= size) begin
          lane_in_node  <= 2'd0;
          node_position <= node_position + PCW'(1);
        end else begin
          lane_in_node <= lane + 2'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Ping-pong frame memory: write the folded byte into the write bank, read the
  // previous frame in order from the other bank. The banks never overlap.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] frame_banks [2*MAX_CHANNELS];
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign wr_addr = write_bank ? (AW'(dest_idx) + BANK_OFS) : AW'(dest_idx);
  assign rd_addr = write_bank ? AW'(pos_idx) : (AW'(pos_idx) + BANK_OFS);

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_banks[wr_addr] <= s_tdata;
      rd_data              <= frame_banks[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage (rd_data) then output register; the read stage holds on stall.
  // ---------------------------------------------------------------------------
  logic rd_valid, rd_last;
  logic adv;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !rd_valid || adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        rd_valid <= previous_frame_ready;
        rd_last  <= frame_end;
      end else if (adv) begin
        rd_valid <= 1'b0;
      end
      if (adv) begin
        m_tvalid <= rd_valid;
        m_tdata  <= rd_data;
        m_tlast  <= rd_last;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // no result is queued for a request taken before any frame completed
  a_first_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && !previous_frame_ready) |=> !rd_valid)
    else $error("result queued before first frame completed");

  // a stalled read stage keeps its contents
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && !adv && !accept) |=> (rd_valid && $stable(rd_last) && $stable(rd_data)))
    else $error("read stage lost data during stall");

  // the last byte of a frame swaps banks and restarts the position
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> (channel_position == '0 && write_bank != $past(write_bank)))
    else $error("frame end did not swap banks");

  // position counter never runs past capacity
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    WW'(channel_position) <= MAX_W)
    else $error("channel position beyond capacity");

endmodule
